[design/vpis_pkg.sv]
package vpis_pkg;

	// Request codes
	localparam logic [2:0] FUNC_WRITE    = 3'd0;
	localparam logic [2:0] FUNC_READ     = 3'd1;
	localparam logic [2:0] FUNC_CA1      = 3'd2;
	localparam logic [2:0] FUNC_CA2      = 3'd3;
	localparam logic [2:0] FUNC_SHIFT_RX = 3'd4;

	// Register indexes
	localparam logic [3:0] REG_ORB       = 4'd0;
	localparam logic [3:0] REG_ORA       = 4'd1;
	localparam logic [3:0] REG_DDRB      = 4'd2;
	localparam logic [3:0] REG_DDRA      = 4'd3;
	localparam logic [3:0] REG_SR        = 4'd10;
	localparam logic [3:0] REG_ACR       = 4'd11;
	localparam logic [3:0] REG_IFR       = 4'd13;
	localparam logic [3:0] REG_IER       = 4'd14;
	localparam logic [3:0] REG_ORA_ALIAS = 4'd15;

	// Shift register modes, ACR bits 4..2
	localparam logic [7:0] SR_MODE_MASK = 8'h1c;
	localparam logic [7:0] SR_MODE_TX   = 8'h1c;
	localparam logic [7:0] SR_MODE_CLR  = 8'h18;
	localparam logic [7:0] SR_MODE_RX   = 8'h0c;

	// Flag bits
	localparam int FLAG_CA1 = 0;
	localparam int FLAG_CA2 = 1;
	localparam int FLAG_SR  = 2;

	localparam logic [7:0] ORA_RESET = 8'h10;

	typedef struct packed {
		logic [2:0] func;
		logic [3:0] reg_index;
		logic [7:0] data_in;
		logic [7:0] port_a_pins;
		logic [7:0] port_b_pins;
	} vpis_cmd_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq_out;
		logic       port_a_changed;
		logic [7:0] port_a_value;
		logic       port_b_changed;
		logic [7:0] port_b_value;
		logic       shift_tx_valid;
		logic [7:0] shift_tx_byte;
	} vpis_res_t;

endpackage

[design/vpis_core.sv]
module vpis_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  vpis_pkg::vpis_cmd_t cmd,
	output vpis_pkg::vpis_res_t res
);
	import vpis_pkg::*;

	logic [7:0] rf_q [16];
	logic [2:0] flags_q;
	logic [6:0] en_q;
	logic       tx_pend_q;
	logic [7:0] tx_byte_q;

	logic [2:0] flags_d;
	logic [6:0] en_d;
	logic       tx_pend_d;
	logic [7:0] tx_byte_d;
	logic       rf_we;
	logic [3:0] rf_wa;
	logic [7:0] rf_wd;
	logic [7:0] mode;
	logic [7:0] porta_mix;
	logic [7:0] portb_mix;
	logic [2:0] acked;
	logic       is_ora;

	assign mode      = rf_q[REG_ACR] & SR_MODE_MASK;
	assign porta_mix = (rf_q[REG_DDRA] & rf_q[REG_ORA]) | (~rf_q[REG_DDRA] & cmd.port_a_pins);
	assign portb_mix = (rf_q[REG_DDRB] & rf_q[REG_ORB]) | (~rf_q[REG_DDRB] & cmd.port_b_pins);
	assign acked     = flags_q & cmd.data_in[2:0];
	assign is_ora    = (cmd.reg_index == REG_ORA) || (cmd.reg_index == REG_ORA_ALIAS);

	// Next state and result for one request
	always_comb begin
		flags_d   = flags_q;
		en_d      = en_q;
		tx_pend_d = tx_pend_q;
		tx_byte_d = tx_byte_q;
		rf_we     = 1'b0;
		rf_wa     = cmd.reg_index;
		rf_wd     = cmd.data_in;
		res       = '0;
		case (cmd.func)
			FUNC_WRITE: begin
				rf_we = 1'b1;
				if (is_ora) begin
					rf_wa = REG_ORA;
					if (rf_q[REG_ORA] != cmd.data_in) begin
						res.port_a_changed = 1'b1;
						res.port_a_value   = cmd.data_in;
					end
				end else if (cmd.reg_index == REG_ORB) begin
					if (rf_q[REG_ORB] != cmd.data_in) begin
						res.port_b_changed = 1'b1;
						res.port_b_value   = cmd.data_in;
					end
				end else if (cmd.reg_index == REG_SR) begin
					// SR writes are never stored as-is
					rf_we = 1'b0;
					if (mode == SR_MODE_TX) begin
						tx_byte_d        = cmd.data_in;
						tx_pend_d        = 1'b1;
						flags_d[FLAG_SR] = 1'b1;
					end else if (mode == SR_MODE_CLR) begin
						rf_we = 1'b1;
						rf_wd = '0;
					end
				end else if (cmd.reg_index == REG_IER) begin
					if (cmd.data_in[7])
						en_d = en_q | cmd.data_in[6:0];
					else
						en_d = en_q & ~cmd.data_in[6:0];
				end else if (cmd.reg_index == REG_IFR) begin
					flags_d = flags_q & ~cmd.data_in[2:0];
					// acking SR releases a pending transmit byte
					if (acked[FLAG_SR] && tx_pend_q) begin
						res.shift_tx_valid = 1'b1;
						res.shift_tx_byte  = tx_byte_q;
						tx_pend_d          = 1'b0;
						tx_byte_d          = '0;
					end
				end
			end
			FUNC_READ: begin
				res.read_data = rf_q[cmd.reg_index];
				if (is_ora)
					res.read_data = porta_mix;
				else if (cmd.reg_index == REG_ORB)
					res.read_data = portb_mix;
				else if (cmd.reg_index == REG_SR)
					flags_d[FLAG_SR] = 1'b0;
				else if (cmd.reg_index == REG_IER)
					res.read_data = {1'b1, en_q};
				else if (cmd.reg_index == REG_IFR)
					res.read_data = {|(en_q[2:0] & flags_q), 4'b0, flags_q};
			end
			FUNC_CA1: flags_d[FLAG_CA1] = 1'b1;
			FUNC_CA2: flags_d[FLAG_CA2] = 1'b1;
			FUNC_SHIFT_RX: begin
				if (mode == SR_MODE_RX) begin
					rf_we            = 1'b1;
					rf_wa            = REG_SR;
					flags_d[FLAG_SR] = 1'b1;
				end
			end
			default: ;
		endcase
		res.irq_out = |(en_d[2:0] & flags_d);
	end

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++)
				rf_q[4'(i)] <= (4'(i) == REG_ORA) ? ORA_RESET : 8'h00;
			flags_q       <= '0;
			en_q          <= '0;
			tx_pend_q     <= 1'b0;
			tx_byte_q     <= '0;
		end else if (fire) begin
			if (rf_we)
				rf_q[rf_wa] <= rf_wd;
			flags_q   <= flags_d;
			en_q      <= en_d;
			tx_pend_q <= tx_pend_d;
			tx_byte_q <= tx_byte_d;
		end
	end

endmodule

[design/via_port_irq_shift_peripheral.sv]
// Channel | Direction | Handshake           | Payload
// cmd     | in        | cmd_valid/cmd_stall | vpis_cmd_t: func, reg_index, data, pins
// res     | out       | res_valid/res_stall | vpis_res_t: read data, irq, port and tx events
//
// A request accepted into the input register moves on into the result register
// once that register is empty or its result is not stalled, and is then valid there.
// A new request can be taken every cycle unless cmd_stall is high; state updates as a request moves
// into the result register. Reset clears the register file (ORA to 0x10),
// flags, enables and the pending transmit byte. A stalled result holds and
// backs up the input register, and cmd_stall rises only when both are full.
module via_port_irq_shift_peripheral (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  vpis_pkg::vpis_cmd_t cmd,
	output logic                res_valid,
	input  logic                res_stall,
	output vpis_pkg::vpis_res_t res
);
	import vpis_pkg::*;

	vpis_cmd_t cmd_s1;
	logic      vld_s1;
	vpis_res_t res_q;
	logic      res_valid_q;
	vpis_res_t res_next;
	logic      advance;
	logic      accept;

	assign advance   = vld_s1 && (!res_valid_q || !res_stall);
	assign cmd_stall = vld_s1 && res_valid_q && res_stall;
	assign accept    = cmd_valid && !cmd_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	vpis_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.cmd    (cmd_s1),
		.res    (res_next)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept || (vld_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			cmd_s1 <= cmd;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res_next;
	end

endmodule
